FILE: hdl/itc_pkg.sv
package itc_pkg;

	// table geometry
	localparam int MAX_POINTS      = 10;
	localparam int WORDS_PER_POINT = 25;
	localparam int TAB_DEPTH       = MAX_POINTS * WORDS_PER_POINT;
	localparam int TAB_AW          = $clog2(TAB_DEPTH);
	localparam int PT_W            = $clog2(MAX_POINTS);
	localparam int CNT_W           = $clog2(MAX_POINTS + 1);
	localparam int K_DEPTH         = 32;
	localparam int K_AW            = $clog2(K_DEPTH);

	// word layout inside one point
	localparam logic [4:0] W_TEMP  = 5'd0;
	localparam logic [4:0] W_ACC_M = 5'd1;
	localparam logic [4:0] W_GYR_M = 5'd10;
	localparam logic [4:0] W_ACC_B = 5'd19;
	localparam logic [4:0] W_GYR_B = 5'd22;
	localparam logic [4:0] W_LAST  = 5'd24;

	// opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_EQUAL = 2'd2;

	// half of one Q16.16 step in Q32.32
	localparam logic [66:0] ROUND_HALF = 67'd32768;
	// any magnitude above the 32 bit limits
	localparam logic [50:0] SAT_BIG    = 51'h1_0000_0000;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         point_index;
		logic [4:0]         word_index;
		logic signed [31:0] table_value;
		logic signed [31:0] sample_temperature;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] gyro_x;
		logic signed [31:0] gyro_y;
		logic signed [31:0] gyro_z;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] out_accel_x;
		logic signed [31:0] out_accel_y;
		logic signed [31:0] out_accel_z;
		logic signed [31:0] out_gyro_x;
		logic signed [31:0] out_gyro_y;
		logic signed [31:0] out_gyro_z;
		logic [1:0]         comp_status;
	} rsp_item_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_sts_t;

	// address of one word of one point
	function automatic logic [TAB_AW-1:0] tab_addr(input logic [PT_W-1:0] p,
		input logic [4:0] w);
		return TAB_AW'(int'(p) * WORDS_PER_POINT + int'(w));
	endfunction

	// clamp a magnitude to the signed 32 bit range and apply the sign
	function automatic logic signed [31:0] sat32(input logic neg, input logic [50:0] mag);
		logic [50:0] lim;
		logic [31:0] m;
		lim = neg ? 51'h8000_0000 : 51'h7FFF_FFFF;
		m   = (mag > lim) ? lim[31:0] : mag[31:0];
		return neg ? $signed(-m) : $signed(m);
	endfunction

endpackage

FILE: hdl/itc_ram.sv
module itc_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/itc_div.sv
module itc_div import itc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [66:0] num,
	input  logic signed [32:0] den,
	output div_sts_t           sts
);

	typedef enum logic [1:0] {D_IDLE, D_PREP, D_ITER, D_FIN} dstate_t;

	dstate_t     state_q;
	logic        neg_q;
	logic        sat_q;
	logic [65:0] n_q;
	logic [32:0] d_q;
	logic [32:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] q_q;
	logic [4:0]  cnt_q;

	logic [33:0] rem2;
	logic        fit;
	logic        rnd;

	// one quotient bit per cycle
	assign rem2 = {rem_q, low_q[31]};
	assign fit  = rem2 >= {1'b0, d_q};
	assign rnd  = {rem_q, 1'b0} >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			sts.done <= 1'b0;
		end else begin
			sts.done <= (state_q == D_FIN);
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= num[66] ^ den[32];
						n_q     <= num[66] ? 66'(-num) : 66'(num);
						d_q     <= den[32] ? 33'(-den) : 33'(den);
						state_q <= D_PREP;
					end
				end
				// quotient of 2^32 or more saturates at once
				D_PREP: begin
					if (n_q[65:32] >= {1'b0, d_q}) begin
						sat_q   <= 1'b1;
						state_q <= D_FIN;
					end else begin
						sat_q   <= 1'b0;
						rem_q   <= n_q[64:32];
						low_q   <= n_q[31:0];
						cnt_q   <= '0;
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					rem_q <= fit ? 33'(rem2 - {1'b0, d_q}) : rem2[32:0];
					q_q   <= {q_q[30:0], fit};
					low_q <= {low_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= D_FIN;
					end
				end
				// round half away from zero, then clamp
				D_FIN: begin
					sts.quo  <= sat32(neg_q, sat_q ? SAT_BIG : 51'(q_q) + 51'(rnd));
					state_q  <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/imu_temperature_compensation_core.sv
// channel | direction | handshake             | beat
// req     | in        | req_valid / req_ready | one table write or one sample
// rsp     | out       | rsp_valid / rsp_ready | one compensated sample
// cfg     | in        | cfg_wr_en             | points_in_use, no wait
//
// A table write leaves the sequencer idle. A sample with an empty table goes
// straight to the output, with one point it skips interpolation, with n points
// it runs the bit-serial divider once for each of 24 words, which dominates.
// Reset clears control state only; table words are undefined until written.
// A new beat is taken while a finished result still waits on rsp.
module imu_temperature_compensation_core import itc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp
);

	typedef enum logic [4:0] {
		S_IDLE, S_SC1_RD, S_SC1_EV, S_DECIDE, S_INIT_RD, S_INIT_EV, S_SC2_RD, S_SC2_EV,
		S_PAIR, S_IP_RD1, S_IP_MUL1, S_IP_MUL2, S_IP_SUB, S_IP_GO, S_IP_WAIT,
		S_MB_RD, S_MB_EV, S_MM_RD, S_MM_MUL, S_MM_ACC, S_RND1, S_RND2, S_PUSH
	} state_t;

	state_t             state_q;
	logic [3:0]         pts_q;
	req_item_t          smp_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   i_q;
	logic [PT_W-1:0]    lo_q;
	logic [PT_W-1:0]    hi_q;
	logic signed [31:0] tlo_q;
	logic signed [31:0] thi_q;
	logic               below_q;
	logic               above_q;
	logic               single_q;
	logic [1:0]         status_q;
	logic signed [32:0] a_q;
	logic signed [32:0] b_q;
	logic signed [32:0] den_q;
	logic signed [64:0] p1_q;
	logic signed [64:0] p2_q;
	logic signed [66:0] num_q;
	logic [4:0]         w_q;
	logic               g_q;
	logic [1:0]         c_q;
	logic [1:0]         r_q;
	logic signed [32:0] d_q [3];
	logic signed [66:0] acc_q;
	logic               rnd_neg_q;
	logic [66:0]        rnd_mag_q;
	logic signed [31:0] res_q [6];
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               req_acc;
	logic               tab_we;
	logic [TAB_AW-1:0]  tab_waddr;
	logic [TAB_AW-1:0]  tab_raddr;
	logic [31:0]        tab_rdata;
	logic               k_we;
	logic [31:0]        k_rdata;
	logic [4:0]         coef_w;
	logic signed [31:0] coef;
	logic signed [31:0] ti;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [31:0] raw [6];
	logic [2:0]         bias_idx;
	logic [2:0]         res_idx;
	logic [66:0]        acc_abs;
	logic [CNT_W-1:0]   lo_inc;
	logic [CNT_W-1:0]   hi_inc;
	logic               last_i;
	logic               start_div;
	div_sts_t           div_sts;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// raw readings in lane order
	assign raw[0] = smp_q.accel_x;
	assign raw[1] = smp_q.accel_y;
	assign raw[2] = smp_q.accel_z;
	assign raw[3] = smp_q.gyro_x;
	assign raw[4] = smp_q.gyro_y;
	assign raw[5] = smp_q.gyro_z;

	assign bias_idx = g_q ? 3'(c_q) + 3'd3 : 3'(c_q);
	assign res_idx  = g_q ? 3'(r_q) + 3'd3 : 3'(r_q);
	assign last_i   = (i_q == n_q - CNT_W'(1));
	assign lo_inc   = CNT_W'(lo_q) + CNT_W'(1);
	assign hi_inc   = CNT_W'(hi_q) + CNT_W'(1);
	assign ti       = $signed(tab_rdata);

	// coefficient word: bias in the bias phase, matrix entry r + 3c otherwise
	always_comb begin
		if (state_q == S_MB_RD) begin
			coef_w = (g_q ? W_GYR_B : W_ACC_B) + 5'(c_q);
		end else begin
			coef_w = (g_q ? W_GYR_M : W_ACC_M) + 5'(r_q) + 5'(c_q) * 5'd3;
		end
	end
	assign coef = single_q ? $signed(tab_rdata) : $signed(k_rdata);

	// table write from an accepted write beat
	assign tab_we = req_acc && (req.opcode == OP_WRITE)
		&& (int'(req.point_index) < MAX_POINTS) && (int'(req.word_index) < WORDS_PER_POINT);
	assign tab_waddr = TAB_AW'(int'(req.point_index) * WORDS_PER_POINT + int'(req.word_index));

	// table read address by sequencer step
	always_comb begin
		case (state_q)
			S_SC1_RD, S_SC2_RD: tab_raddr = tab_addr(i_q[PT_W-1:0], W_TEMP);
			S_INIT_RD:          tab_raddr = tab_addr(below_q ? hi_q : lo_q, W_TEMP);
			S_IP_RD1:           tab_raddr = tab_addr(lo_q, w_q);
			S_IP_MUL1:          tab_raddr = tab_addr(hi_q, w_q);
			S_MB_RD, S_MM_RD:   tab_raddr = tab_addr('0, coef_w);
			default:            tab_raddr = '0;
		endcase
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			S_IP_MUL1: begin
				mul_a = a_q;
				mul_b = ti;
			end
			S_IP_MUL2: begin
				mul_a = b_q;
				mul_b = ti;
			end
			default: begin
				mul_a = d_q[c_q];
				mul_b = coef;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign acc_abs   = acc_q[66] ? 67'(-acc_q) : 67'(acc_q);
	assign start_div = (state_q == S_IP_GO);
	assign k_we      = (state_q == S_IP_WAIT) && div_sts.done;

	itc_ram #(.DEPTH(TAB_DEPTH), .WIDTH(32)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (req.table_value),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	itc_ram #(.DEPTH(K_DEPTH), .WIDTH(32)) u_coef (
		.clk   (clk),
		.we    (k_we),
		.waddr (K_AW'(w_q)),
		.wdata (div_sts.quo),
		.raddr (K_AW'(coef_w)),
		.rdata (k_rdata)
	);

	itc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_div),
		.num    (num_q),
		.den    (den_q),
		.sts    (div_sts)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cfg_wr_en) begin
			pts_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_PUSH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req.opcode == OP_SAMPLE) begin
						smp_q    <= req;
						single_q <= (pts_q == 4'd1);
						status_q <= (pts_q == 4'd0) ? ST_EMPTY : ST_OK;
						g_q      <= 1'b0;
						c_q      <= '0;
						r_q      <= '0;
						acc_q    <= '0;
						i_q      <= '0;
						n_q      <= (int'(pts_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
							: CNT_W'(pts_q);
						if (pts_q == 4'd0) begin
							state_q  <= S_PUSH;
						end else if (pts_q == 4'd1) begin
							state_q  <= S_MB_RD;
						end else begin
							state_q <= S_SC1_RD;
						end
					end
				end
				// coolest and warmest point
				S_SC1_RD: state_q <= S_SC1_EV;
				S_SC1_EV: begin
					if (i_q == '0) begin
						lo_q  <= '0;
						hi_q  <= '0;
						tlo_q <= ti;
						thi_q <= ti;
					end else begin
						if (ti > thi_q) begin
							hi_q  <= i_q[PT_W-1:0];
							thi_q <= ti;
						end
						if (ti < tlo_q) begin
							lo_q  <= i_q[PT_W-1:0];
							tlo_q <= ti;
						end
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= last_i ? S_DECIDE : S_SC1_RD;
				end
				S_DECIDE: begin
					below_q <= smp_q.sample_temperature < tlo_q;
					above_q <= smp_q.sample_temperature > thi_q;
					i_q     <= '0;
					if (smp_q.sample_temperature < tlo_q) begin
						hi_q    <= (lo_inc == n_q) ? '0 : lo_inc[PT_W-1:0];
						state_q <= S_INIT_RD;
					end else if (smp_q.sample_temperature > thi_q) begin
						lo_q    <= (hi_inc == n_q) ? '0 : hi_inc[PT_W-1:0];
						state_q <= S_INIT_RD;
					end else begin
						state_q <= S_SC2_RD;
					end
				end
				// temperature of the restarted pair member
				S_INIT_RD: state_q <= S_INIT_EV;
				S_INIT_EV: begin
					if (below_q) begin
						thi_q <= ti;
					end else begin
						tlo_q <= ti;
					end
					state_q <= S_SC2_RD;
				end
				// narrow the pair around the sample temperature
				S_SC2_RD: state_q <= S_SC2_EV;
				S_SC2_EV: begin
					if (below_q) begin
						if (ti < thi_q && i_q[PT_W-1:0] != lo_q) begin
							hi_q  <= i_q[PT_W-1:0];
							thi_q <= ti;
						end
					end else if (above_q) begin
						if (ti > tlo_q && i_q[PT_W-1:0] != hi_q) begin
							lo_q  <= i_q[PT_W-1:0];
							tlo_q <= ti;
						end
					end else begin
						if (ti > smp_q.sample_temperature && ti < thi_q) begin
							hi_q  <= i_q[PT_W-1:0];
							thi_q <= ti;
						end
						if (ti < smp_q.sample_temperature && ti > tlo_q) begin
							lo_q  <= i_q[PT_W-1:0];
							tlo_q <= ti;
						end
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= last_i ? S_PAIR : S_SC2_RD;
				end
				S_PAIR: begin
					a_q   <= 33'(smp_q.sample_temperature) - 33'(thi_q);
					b_q   <= 33'(smp_q.sample_temperature) - 33'(tlo_q);
					den_q <= 33'(tlo_q) - 33'(thi_q);
					w_q   <= W_ACC_M;
					if (tlo_q == thi_q) begin
						status_q <= ST_EQUAL;
						state_q  <= S_PUSH;
					end else begin
						state_q <= S_IP_RD1;
					end
				end
				// interpolate one word
				S_IP_RD1: state_q <= S_IP_MUL1;
				S_IP_MUL1: begin
					p1_q    <= mul_p;
					state_q <= S_IP_MUL2;
				end
				S_IP_MUL2: begin
					p2_q    <= mul_p;
					state_q <= S_IP_SUB;
				end
				S_IP_SUB: begin
					num_q   <= 67'(p1_q) - 67'(p2_q);
					state_q <= S_IP_GO;
				end
				S_IP_GO: state_q <= S_IP_WAIT;
				S_IP_WAIT: begin
					if (div_sts.done) begin
						if (w_q == W_LAST) begin
							state_q <= S_MB_RD;
						end else begin
							w_q     <= w_q + 5'd1;
							state_q <= S_IP_RD1;
						end
					end
				end
				// bias differences of one sensor
				S_MB_RD: state_q <= S_MB_EV;
				S_MB_EV: begin
					d_q[c_q] <= 33'(raw[bias_idx]) - 33'(coef);
					if (c_q == 2'd2) begin
						c_q     <= '0;
						state_q <= S_MM_RD;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_MB_RD;
					end
				end
				// one row of the matrix product
				S_MM_RD: state_q <= S_MM_MUL;
				S_MM_MUL: begin
					p1_q    <= mul_p;
					state_q <= S_MM_ACC;
				end
				S_MM_ACC: begin
					acc_q <= acc_q + 67'(p1_q);
					if (c_q == 2'd2) begin
						state_q <= S_RND1;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_MM_RD;
					end
				end
				// Q32.32 to Q16.16, ties away from zero
				S_RND1: begin
					rnd_neg_q <= acc_q[66];
					rnd_mag_q <= acc_abs + ROUND_HALF;
					state_q   <= S_RND2;
				end
				S_RND2: begin
					res_q[res_idx] <= sat32(rnd_neg_q, rnd_mag_q[66:16]);
					acc_q          <= '0;
					c_q            <= '0;
					if (r_q == 2'd2) begin
						r_q <= '0;
						if (g_q) begin
							state_q <= S_PUSH;
						end else begin
							g_q     <= 1'b1;
							state_q <= S_MB_RD;
						end
					end else begin
						r_q     <= r_q + 2'd1;
						state_q <= S_MM_RD;
					end
				end
				// hand the result to the output register
				S_PUSH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.comp_status <= status_q;
						if (status_q == ST_OK) begin
							rsp_q.out_accel_x <= res_q[0];
							rsp_q.out_accel_y <= res_q[1];
							rsp_q.out_accel_z <= res_q[2];
							rsp_q.out_gyro_x  <= res_q[3];
							rsp_q.out_gyro_y  <= res_q[4];
							rsp_q.out_gyro_z  <= res_q[5];
						end else begin
							rsp_q.out_accel_x <= raw[0];
							rsp_q.out_accel_y <= raw[1];
							rsp_q.out_accel_z <= raw[2];
							rsp_q.out_gyro_x  <= raw[3];
							rsp_q.out_gyro_y  <= raw[4];
							rsp_q.out_gyro_z  <= raw[5];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/itc_checker.sv
module itc_checker import itc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_wr_en,
	input logic [3:0] cfg_wr_data,
	input logic       req_valid,
	input logic       req_ready,
	input req_item_t  req,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input rsp_item_t  rsp
);

	// a waiting result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// only defined status codes leave the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.comp_status == ST_OK || rsp.comp_status == ST_EMPTY
			|| rsp.comp_status == ST_EQUAL))
		else $error("undefined status code");

	// a table write never creates a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == OP_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("result after table write");

	// an accepted sample drops req_ready in the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == OP_SAMPLE |=> !req_ready)
		else $error("sample accepted without busy cycle");

endmodule

bind imu_temperature_compensation_core itc_checker u_itc_checker (.*);

FILE: tb/sv/imu_temperature_compensation_core_tb.sv
`timescale 1ns / 1ps

module imu_temperature_compensation_core_tb;
	import itc_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// predictor copy of the calibration words and the point count
	logic signed [31:0] cal_words [0:TAB_DEPTH-1];
	logic [3:0]         cal_pts;

	req_item_t pending_beats [$];
	rsp_item_t comp_due [$];
	logic      beat_taken;
	int        req_idle, rsp_idle;
	logic      calm;
	int        errors;

	imu_temperature_compensation_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// round num/den to nearest, ties away from zero, clamp to 32 bits
	function automatic logic signed [31:0] div_round_clamp(logic signed [127:0] num,
		logic signed [127:0] den);
		logic [127:0] nm, dm, q, rm, lim;
		logic         neg;
		neg = num[127] ^ den[127];
		nm  = num[127] ? -num : num;
		dm  = den[127] ? -den : den;
		q   = nm / dm;
		rm  = nm % dm;
		if (rm >= dm - rm)
			q = q + 1;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim)
			q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	// expected compensated sample for the current table and point count
	function automatic rsp_item_t compensate(req_item_t s);
		logic signed [127:0] t, t1, t2, y1, y2, num, acc;
		logic signed [127:0] raw [6];
		logic signed [127:0] k [WORDS_PER_POINT];
		logic signed [127:0] d [3];
		logic signed [31:0]  tmin, tmax, ti;
		logic signed [31:0]  res [6];
		logic [1:0]          st;
		int                  n, lo, hi, i, w, r, c, mb, bb;
		rsp_item_t           o;
		t = s.sample_temperature;
		raw[0] = s.accel_x; raw[1] = s.accel_y; raw[2] = s.accel_z;
		raw[3] = s.gyro_x;  raw[4] = s.gyro_y;  raw[5] = s.gyro_z;
		n  = (cal_pts > MAX_POINTS) ? MAX_POINTS : cal_pts;
		st = ST_OK;
		if (n == 0) begin
			st = ST_EMPTY;
		end else if (n == 1) begin
			for (w = 0; w < WORDS_PER_POINT; w++)
				k[w] = cal_words[w];
		end else begin
			lo = 0; hi = 0;
			for (i = 1; i < n; i++) begin
				if (cal_words[i*WORDS_PER_POINT] > cal_words[hi*WORDS_PER_POINT]) hi = i;
				if (cal_words[i*WORDS_PER_POINT] < cal_words[lo*WORDS_PER_POINT]) lo = i;
			end
			tmin = cal_words[lo*WORDS_PER_POINT];
			tmax = cal_words[hi*WORDS_PER_POINT];
			// bracketing pair inside the table span
			if (s.sample_temperature >= tmin && s.sample_temperature <= tmax) begin
				for (i = 0; i < n; i++) begin
					ti = cal_words[i*WORDS_PER_POINT];
					if (ti > s.sample_temperature && ti < cal_words[hi*WORDS_PER_POINT]) hi = i;
					if (ti < s.sample_temperature && ti > cal_words[lo*WORDS_PER_POINT]) lo = i;
				end
			end
			// nearest two below the span
			if (s.sample_temperature < tmin) begin
				hi = (lo + 1) % n;
				for (i = 0; i < n; i++)
					if (cal_words[i*WORDS_PER_POINT] < cal_words[hi*WORDS_PER_POINT] && i != lo)
						hi = i;
			end
			// nearest two above the span
			if (s.sample_temperature > tmax) begin
				lo = (hi + 1) % n;
				for (i = 0; i < n; i++)
					if (cal_words[i*WORDS_PER_POINT] > cal_words[lo*WORDS_PER_POINT] && i != hi)
						lo = i;
			end
			t1 = cal_words[lo*WORDS_PER_POINT];
			t2 = cal_words[hi*WORDS_PER_POINT];
			if (t1 == t2) begin
				st = ST_EQUAL;
			end else begin
				for (w = 1; w < WORDS_PER_POINT; w++) begin
					y1   = cal_words[lo*WORDS_PER_POINT + w];
					y2   = cal_words[hi*WORDS_PER_POINT + w];
					num  = (t - t2) * y1 - (t - t1) * y2;
					k[w] = div_round_clamp(num, t1 - t2);
				end
			end
		end
		// bias removal and matrix product, or raw passthrough
		for (i = 0; i < 6; i++)
			res[i] = raw[i][31:0];
		if (st == ST_OK) begin
			for (i = 0; i < 2; i++) begin
				mb = (i == 0) ? W_ACC_M : W_GYR_M;
				bb = (i == 0) ? W_ACC_B : W_GYR_B;
				for (c = 0; c < 3; c++)
					d[c] = raw[3*i + c] - k[bb + c];
				for (r = 0; r < 3; r++) begin
					acc = 0;
					for (c = 0; c < 3; c++)
						acc = acc + k[mb + r + 3*c] * d[c];
					res[3*i + r] = div_round_clamp(acc, 128'sd65536);
				end
			end
		end
		o.out_accel_x = res[0]; o.out_accel_y = res[1]; o.out_accel_z = res[2];
		o.out_gyro_x  = res[3]; o.out_gyro_y  = res[4]; o.out_gyro_z  = res[5];
		o.comp_status = st;
		return o;
	endfunction

	// accepted request beat: update the table copy or queue the expected result
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			beat_taken <= 1'b1;
			void'(pending_beats.pop_front());
			if (req.opcode == OP_WRITE) begin
				if (req.point_index < MAX_POINTS && req.word_index < WORDS_PER_POINT)
					cal_words[req.point_index*WORDS_PER_POINT + req.word_index] = req.table_value;
			end else begin
				comp_due.push_back(compensate(req));
			end
		end
	end

	// request driver with idle bursts
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !beat_taken)) begin
			beat_taken <= 1'b0;
			if (req_idle > 0) begin
				req_valid <= 1'b0;
				req_idle  <= req_idle - 1;
			end else if (pending_beats.size() == 0) begin
				req_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				req_valid <= 1'b0;
				req_idle  <= $urandom_range(0, 2);
			end else begin
				req_valid <= 1'b1;
				req       <= pending_beats[0];
			end
		end
	end

	// response stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_idle > 0) begin
				rsp_ready <= 1'b0;
				rsp_idle  <= rsp_idle - 1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				rsp_idle  <= $urandom_range(0, 2);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $realtime, name, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (comp_due.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat, actual %h", $realtime, rsp);
			end else begin
				want = comp_due.pop_front();
				check_field("out_accel_x", want.out_accel_x, rsp.out_accel_x);
				check_field("out_accel_y", want.out_accel_y, rsp.out_accel_y);
				check_field("out_accel_z", want.out_accel_z, rsp.out_accel_z);
				check_field("out_gyro_x", want.out_gyro_x, rsp.out_gyro_x);
				check_field("out_gyro_y", want.out_gyro_y, rsp.out_gyro_y);
				check_field("out_gyro_z", want.out_gyro_z, rsp.out_gyro_z);
				check_field("comp_status", 32'(want.comp_status), 32'(rsp.comp_status));
			end
		end
	end

	function automatic logic signed [31:0] pick_temp();
		logic signed [31:0] pool [7] = '{-40, -10, 0, 25, 25, 60, 85};
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2, 3: return pool[$urandom_range(0, 6)] * 65536;
			default: return $signed($urandom_range(0, 170 * 65536)) - 60 * 65536;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_word(int w);
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		if (w == W_TEMP)
			return pick_temp();
		if (w < W_ACC_B && ((w - 1) % 9) % 4 == 0)
			return 65536 + $signed($urandom_range(0, 8191)) - 4096;
		return $signed($urandom_range(0, 16383)) - 8192;
	endfunction

	function automatic logic signed [31:0] pick_reading();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $signed($urandom_range(0, 32 * 65536)) - 16 * 65536;
	endfunction

	function automatic req_item_t make_write(int p, int w, logic signed [31:0] v);
		req_item_t r;
		r = '0;
		r.opcode      = OP_WRITE;
		r.point_index = 4'(p);
		r.word_index  = 5'(w);
		r.table_value = v;
		r.sample_temperature = $urandom;
		r.accel_x = $urandom;
		r.gyro_z  = $urandom;
		return r;
	endfunction

	function automatic req_item_t make_sample(logic signed [31:0] t, logic signed [31:0] a);
		req_item_t r;
		r = '0;
		r.opcode             = OP_SAMPLE;
		r.point_index        = 4'($urandom);
		r.word_index         = 5'($urandom);
		r.table_value        = $urandom;
		r.sample_temperature = t;
		r.accel_x = a;             r.accel_y = pick_reading(); r.accel_z = -a;
		r.gyro_x  = pick_reading(); r.gyro_y = ~a;             r.gyro_z  = pick_reading();
		return r;
	endfunction

	task automatic random_beats(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 4) begin
				if ($urandom_range(0, 15) == 0)
					pending_beats.push_back(make_write($urandom_range(0, 15),
						$urandom_range(0, 31), $urandom));
				else begin
					int w = $urandom_range(0, 24);
					pending_beats.push_back(make_write($urandom_range(0, 9), w, pick_word(w)));
				end
			end else begin
				pending_beats.push_back(make_sample(pick_temp(), pick_reading()));
			end
		end
	endtask

	// wait until idle, then load a new point count
	task automatic set_points(logic [3:0] v);
		wait (pending_beats.size() == 0 && comp_due.size() == 0);
		repeat (1200) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		cal_pts     = v;
	endtask

	initial begin
		logic [3:0] phase_pts [10] = '{1, 2, 3, 10, 15, 5, 2, 4, 1, 7};
		errors      = 0;
		calm        = 1'b0;
		beat_taken  = 1'b0;
		req_idle    = 0;
		rsp_idle    = 0;
		cal_pts     = '0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table passthrough and ignored writes
		pending_beats.push_back(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000));
		pending_beats.push_back(make_sample(32'sh8000_0000, 32'sh7FFF_FFFF));
		pending_beats.push_back(make_write(15, 3, 32'sh7FFF_FFFF));
		pending_beats.push_back(make_write(2, 31, 32'sh8000_0000));
		// full table fill with distinct point temperatures
		for (int p = 0; p < MAX_POINTS; p++)
			for (int w = 0; w < WORDS_PER_POINT; w++)
				pending_beats.push_back(make_write(p, w,
					(w == 0) ? (-40 + 15 * p) * 65536 : pick_word(w)));
		set_points(4'd0);

		// one point, then pairs inside, below and above, then equal temperatures
		set_points(4'd1);
		pending_beats.push_back(make_sample(0, 32'sh8000_0000));
		pending_beats.push_back(make_sample(5 * 65536, 32'sh7FFF_FFFF));
		set_points(4'd3);
		pending_beats.push_back(make_sample(-20 * 65536, 65536));
		pending_beats.push_back(make_sample(-25 * 65536, 65536));
		pending_beats.push_back(make_sample(-90 * 65536, 0));
		pending_beats.push_back(make_sample(30 * 65536, 0));
		pending_beats.push_back(make_sample(32'sh8000_0000, 32'sh8000_0000));
		pending_beats.push_back(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		pending_beats.push_back(make_write(1, 0, -40 * 65536));
		pending_beats.push_back(make_sample(-30 * 65536, 65536));
		pending_beats.push_back(make_write(1, 0, -25 * 65536));
		set_points(4'd2);
		pending_beats.push_back(make_write(1, 0, -40 * 65536));
		pending_beats.push_back(make_sample(0, 3 * 65536));
		pending_beats.push_back(make_write(1, 0, -25 * 65536));
		pending_beats.push_back(make_sample(-30 * 65536, 3 * 65536));

		// random phases across point counts, last phase without stalls
		for (int ph = 0; ph < 10; ph++) begin
			set_points(phase_pts[ph]);
			if (ph == 9)
				calm = 1'b1;
			random_beats(125);
		end
		set_points(4'd0);
		random_beats(30);

		wait (pending_beats.size() == 0 && comp_due.size() == 0);
		repeat (1200) @(posedge clk);
		if (errors == 0)
			$display("PASS imu_temperature_compensation_core");
		else
			$display("FAIL imu_temperature_compensation_core");
		$finish;
	end

	// run time guard
	initial begin
		#40ms;
		$display("FAIL imu_temperature_compensation_core");
		$finish;
	end

endmodule

FILE: imu_temperature_compensation_core.f
hdl/itc_pkg.sv
hdl/itc_ram.sv
hdl/itc_div.sv
hdl/imu_temperature_compensation_core.sv
hdl/itc_checker.sv
tb/sv/imu_temperature_compensation_core_tb.sv
